### rtl/core/bfs_pkg.sv
// Shared constants, types and fixed-point helpers for the biased factor SGD block.
`default_nettype none

package bfs_pkg;

   // Table geometry
   localparam int NUM_USERS   = 65536;
   localparam int NUM_ITEMS   = 32768;
   localparam int NUM_FACTORS = 32;
   localparam int ROW         = NUM_FACTORS + 1;   // bias at slot 0, factors after it
   localparam int SLOT_W      = $clog2(ROW);
   localparam int UIDX_W      = $clog2(NUM_USERS);
   localparam int IIDX_W      = $clog2(NUM_ITEMS);
   localparam int UMEM_DEPTH  = NUM_USERS * ROW;
   localparam int IMEM_DEPTH  = NUM_ITEMS * ROW;
   localparam int UADDR_W     = $clog2(UMEM_DEPTH);
   localparam int IADDR_W     = $clog2(IMEM_DEPTH);

   // Field widths
   localparam int W          = 32;
   localparam int FRAC_W     = 16;
   localparam int MUL_A_W    = 33;
   localparam int MULQ_W     = MUL_A_W + W - FRAC_W;
   localparam int SUM_W      = 56;
   localparam int ACC_W      = MULQ_W + $clog2(ROW) + 2;
   localparam int PRED_W     = 19;
   localparam int ERR_W      = 20;
   localparam int RATE_W     = 16;
   localparam int RATING_W   = 3;
   localparam int ENTRY_W    = 6;
   localparam int CSR_W      = 19;
   localparam int CSR_IDX_W  = 3;

   // Fixed-point constants
   localparam logic [PRED_W-1:0] ONE_Q  = PRED_W'(65536);
   localparam logic [PRED_W-1:0] FIVE_Q = PRED_W'(327680);
   localparam int                ERR_LIM = 262144;
   localparam logic signed [MUL_A_W+W-1:0] HALF_Q = (MUL_A_W+W)'(32768);
   localparam logic signed [SUM_W-1:0] S32_MAX = SUM_W'(2147483647);
   localparam logic signed [SUM_W-1:0] S32_MIN = -S32_MAX - SUM_W'(1);

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_RATING  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_RATE    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_FACTOR_RATE  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_DECAY   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_FACTOR_DECAY = CSR_IDX_W'(4);
   localparam logic [PRED_W-1:0]    MEAN_RESET  = '0;
   localparam logic [RATE_W-1:0]    RATE_RESET  = RATE_W'(524);
   localparam logic [RATE_W-1:0]    DECAY_RESET = RATE_W'(655);

   typedef enum logic [1:0] {
      CMD_TRAIN     = 2'd0,
      CMD_PREDICT   = 2'd1,
      CMD_LOAD_USER = 2'd2,
      CMD_LOAD_ITEM = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOT,
      ST_DOT_WAIT,
      ST_UPD,
      ST_UPD_WAIT
   } state_type;

   // Read data beat returning from both table memories
   typedef struct packed {
      logic              dot;
      logic              upd;
      logic [SLOT_W-1:0] slot;
   } beat_type;

   // Write-back request from the update pipeline
   typedef struct packed {
      logic                 en;
      logic [SLOT_W-1:0]    slot;
      logic signed [W-1:0]  data;
   } wr_type;

   // Control from the sequencer to the prediction unit
   typedef struct packed {
      logic clear;
      logic finish;
      logic train;
      logic many;
   } dot_ctl_type;

   // Q15.16 product rounded half up: floor((a*b + 2^15) / 2^16)
   function automatic logic signed [MULQ_W-1:0] mulq(input logic signed [MUL_A_W-1:0] a,
                                                      input logic signed [W-1:0] b);
      logic signed [MUL_A_W+W-1:0] p;
      p = a * b;
      p = p + HALF_Q;
      return p[MUL_A_W+W-1:FRAC_W];
   endfunction

   // Saturate to the signed 32-bit range
   function automatic logic signed [W-1:0] sat32(input logic signed [SUM_W-1:0] x);
      logic signed [W-1:0] r;
      if (x > S32_MAX) begin
         r = S32_MAX[W-1:0];
      end else if (x < S32_MIN) begin
         r = S32_MIN[W-1:0];
      end else begin
         r = x[W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/bfs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module bfs_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

### rtl/core/bfs_dot.sv
// Prediction unit: accumulates mean, biases and factor products, then clamps and forms the error.
`default_nettype none

module bfs_dot (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bfs_pkg::dot_ctl_type           ctl,
   input  wire bfs_pkg::beat_type              beat,
   input  wire logic signed [bfs_pkg::W-1:0]   rd_user,
   input  wire logic signed [bfs_pkg::W-1:0]   rd_item,
   input  wire logic [bfs_pkg::PRED_W-1:0]     mean,
   input  wire logic [bfs_pkg::RATING_W-1:0]   rating,
   output logic                                pending,
   output logic                                strobe_ff,
   output logic [bfs_pkg::PRED_W-1:0]          pred_ff,
   output logic signed [bfs_pkg::ERR_W-1:0]    err_ff
);

   import bfs_pkg::*;

   localparam int DIFF_W = PRED_W + 3;

   logic                       term_v_ff;
   logic signed [MULQ_W-1:0]   term_ff;
   logic signed [MULQ_W-1:0]   term_in;
   logic signed [ACC_W-1:0]    acc_ff;
   logic [PRED_W-1:0]          pred_in;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [ERR_W-1:0]    err_in;

   // Form one term: biases on slot 0, a factor product otherwise when many is set, else zero
   always_comb begin
      if (beat.slot == '0) begin
         term_in = MULQ_W'(rd_user) + MULQ_W'(rd_item);
      end else if (ctl.many) begin
         term_in = mulq(MUL_A_W'(rd_user), rd_item);
      end else begin
         term_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_v_ff <= 1'b0;
      end else begin
         term_v_ff <= beat.dot;
      end
   end

   // Hold the term, then accumulate it onto the mean
   always_ff @(posedge clock) begin
      term_ff <= term_in;
      if (ctl.clear) begin
         acc_ff <= ACC_W'(mean);
      end else if (term_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(term_ff);
      end
   end

   // Clamp to [1, 5] and form the saturated error, forced to zero unless training
   always_comb begin
      if (acc_ff < signed'(ACC_W'(ONE_Q))) begin
         pred_in = ONE_Q;
      end else if (acc_ff > signed'(ACC_W'(FIVE_Q))) begin
         pred_in = FIVE_Q;
      end else begin
         pred_in = acc_ff[PRED_W-1:0];
      end
      diff = signed'(DIFF_W'({rating, FRAC_W'(0)})) - signed'(DIFF_W'(pred_in));
      if (diff > DIFF_W'(ERR_LIM)) begin
         err_in = ERR_W'(ERR_LIM);
      end else if (diff < -DIFF_W'(ERR_LIM)) begin
         err_in = -ERR_W'(ERR_LIM);
      end else begin
         err_in = diff[ERR_W-1:0];
      end
      if (!ctl.train) begin
         err_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         pred_ff <= pred_in;
         err_ff  <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl.finish;
      end
   end

   assign pending = beat.dot | term_v_ff;

endmodule

`default_nettype wire

### rtl/core/bfs_update.sv
// Update pipeline: one SGD step per table slot, user entry first, then item entry.
`default_nettype none

module bfs_update (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bfs_pkg::beat_type              beat,
   input  wire logic signed [bfs_pkg::W-1:0]   rd_user,
   input  wire logic signed [bfs_pkg::W-1:0]   rd_item,
   input  wire logic signed [bfs_pkg::ERR_W-1:0] err,
   input  wire logic [bfs_pkg::RATE_W-1:0]     bias_rate,
   input  wire logic [bfs_pkg::RATE_W-1:0]     factor_rate,
   input  wire logic [bfs_pkg::RATE_W-1:0]     bias_decay,
   input  wire logic [bfs_pkg::RATE_W-1:0]     factor_decay,
   output bfs_pkg::wr_type                     user_wr,
   output bfs_pkg::wr_type                     item_wr,
   output logic                                pending
);

   import bfs_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic b1_ff, b2_ff, b3_ff, b4_ff;
   logic [SLOT_W-1:0] s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff;
   logic signed [W-1:0] pu1_ff, pu2_ff, pun3_ff;
   logic signed [W-1:0] qi1_ff, qi2_ff, qi3_ff, qi4_ff, qi5_ff, qin6_ff;
   logic signed [MULQ_W-1:0] g1_ff, d1_ff, m1_ff, g2_ff, d2_ff, m2_ff;
   logic signed [MULQ_W-1:0] g1_in, d1_in, m1_in, g2_in, d2_in, m2_in;
   logic signed [W-1:0] t1, t2, pun_in, qin_in;
   logic bias_in;

   function automatic logic signed [MUL_A_W-1:0] coef(input logic bias,
                                                       input logic [RATE_W-1:0] b_val,
                                                       input logic [RATE_W-1:0] f_val);
      logic [RATE_W-1:0] v;
      v = bias ? b_val : f_val;
      return MUL_A_W'(v);
   endfunction

   always_comb begin
      bias_in = (beat.slot == '0);
      // user gradient and decay term
      g1_in = bias_in ? MULQ_W'(err) : mulq(MUL_A_W'(err), rd_item);
      d1_in = mulq(coef(bias_in, bias_decay, factor_decay), rd_user);
      // user step
      t1    = sat32(SUM_W'(g1_ff) - SUM_W'(d1_ff));
      m1_in = mulq(coef(b1_ff, bias_rate, factor_rate), t1);
      pun_in = sat32(SUM_W'(pu2_ff) + SUM_W'(m1_ff));
      // item gradient uses the updated user entry
      g2_in = b3_ff ? MULQ_W'(err) : mulq(MUL_A_W'(err), pun3_ff);
      d2_in = mulq(coef(b3_ff, bias_decay, factor_decay), qi3_ff);
      t2    = sat32(SUM_W'(g2_ff) - SUM_W'(d2_ff));
      m2_in = mulq(coef(b4_ff, bias_rate, factor_rate), t2);
      qin_in = sat32(SUM_W'(qi5_ff) + SUM_W'(m2_ff));
   end

   // Advance stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= beat.upd;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // Advance stage payload
   always_ff @(posedge clock) begin
      b1_ff   <= bias_in;
      s1_ff   <= beat.slot;
      pu1_ff  <= rd_user;
      qi1_ff  <= rd_item;
      g1_ff   <= g1_in;
      d1_ff   <= d1_in;

      b2_ff   <= b1_ff;
      s2_ff   <= s1_ff;
      pu2_ff  <= pu1_ff;
      qi2_ff  <= qi1_ff;
      m1_ff   <= m1_in;

      b3_ff   <= b2_ff;
      s3_ff   <= s2_ff;
      qi3_ff  <= qi2_ff;
      pun3_ff <= pun_in;

      b4_ff   <= b3_ff;
      s4_ff   <= s3_ff;
      qi4_ff  <= qi3_ff;
      g2_ff   <= g2_in;
      d2_ff   <= d2_in;

      s5_ff   <= s4_ff;
      qi5_ff  <= qi4_ff;
      m2_ff   <= m2_in;

      s6_ff   <= s5_ff;
      qin6_ff <= qin_in;
   end

   assign user_wr = '{en: v3_ff, slot: s3_ff, data: pun3_ff};
   assign item_wr = '{en: v6_ff, slot: s6_ff, data: qin6_ff};
   assign pending = beat.upd | v1_ff | v2_ff | v3_ff | v4_ff | v5_ff | v6_ff;

endmodule

`default_nettype wire

### rtl/core/biased_factor_sgd_update.sv
// Top level: sequencer, configuration registers and the two table memories.
// Load commands write at the accepting edge; busy stays low, no result.
// Predict: one read pass; result strobe once it has drained, next start then.
// Train: result as predict, then an update read pass; busy until its write-backs drain.
// The rate is set by the one read port of each table memory: one slot per cycle in a pass.
// Reset clears control and sets the CSRs to defaults; tables stay undefined until loaded.
`default_nettype none

module biased_factor_sgd_update (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        req_command,
   input  wire logic [15:0]                       req_user_index,
   input  wire logic [14:0]                       req_item_index,
   input  wire logic [bfs_pkg::RATING_W-1:0]      req_rating,
   input  wire logic                              req_user_rated_many,
   input  wire logic [bfs_pkg::ENTRY_W-1:0]       req_entry_slot,
   input  wire logic signed [bfs_pkg::W-1:0]      req_load_value,
   output logic                                   rsp_strobe,
   output logic [bfs_pkg::PRED_W-1:0]             rsp_prediction,
   output logic signed [bfs_pkg::ERR_W-1:0]       rsp_error,
   input  wire logic                              csr_write_enable,
   input  wire logic [bfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bfs_pkg::CSR_W-1:0]         csr_write_data
);

   import bfs_pkg::*;

   state_type            state_ff, state_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [UADDR_W-1:0]   ubase_ff;
   logic [IADDR_W-1:0]   ibase_ff;
   logic                 train_ff, many_ff;
   logic [RATING_W-1:0]  rating_ff;
   beat_type             beat_ff;
   logic [PRED_W-1:0]    mean_ff;
   logic [RATE_W-1:0]    bias_rate_ff, factor_rate_ff, bias_decay_ff, factor_decay_ff;

   cmd_type              req_cmd;
   logic                 accept, issue, do_item, slot_ok, load_user, load_item;
   logic [UADDR_W-1:0]   u_row, u_load_addr;
   logic [IADDR_W-1:0]   i_row, i_load_addr;
   dot_ctl_type          dot_ctl;
   logic                 dot_pending, upd_pending;
   wr_type               user_wr, item_wr;
   logic [W-1:0]         rd_user, rd_item;
   logic                 uram_we, iram_we;
   logic [UADDR_W-1:0]   uram_waddr;
   logic [IADDR_W-1:0]   iram_waddr;
   logic [W-1:0]         uram_wdata, iram_wdata;

   // Decode the request beat
   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start & ~busy;
   assign req_cmd     = cmd_type'(req_command);
   assign do_item     = (req_cmd == CMD_TRAIN) || (req_cmd == CMD_PREDICT);
   assign slot_ok     = (32'(req_entry_slot) <= 32'(NUM_FACTORS));
   assign load_user   = accept && (req_cmd == CMD_LOAD_USER) && slot_ok;
   assign load_item   = accept && (req_cmd == CMD_LOAD_ITEM) && slot_ok;
   assign u_row       = UADDR_W'(UIDX_W'(req_user_index)) * UADDR_W'(ROW);
   assign i_row       = IADDR_W'(IIDX_W'(req_item_index)) * IADDR_W'(ROW);
   assign u_load_addr = u_row + UADDR_W'(req_entry_slot);
   assign i_load_addr = i_row + IADDR_W'(req_entry_slot);

   // Sequencer: read pass for prediction, then, for train only, read pass for update
   always_comb begin
      state_in       = state_ff;
      slot_in        = slot_ff;
      issue          = 1'b0;
      dot_ctl.clear  = 1'b0;
      dot_ctl.finish = 1'b0;
      dot_ctl.train  = train_ff;
      dot_ctl.many   = many_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && do_item) begin
               state_in      = ST_DOT;
               slot_in       = '0;
               dot_ctl.clear = 1'b1;
            end
         end
         ST_DOT: begin
            issue = 1'b1;
            if (slot_ff == SLOT_W'(ROW - 1)) begin
               state_in = ST_DOT_WAIT;
               slot_in  = '0;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         ST_DOT_WAIT: begin
            if (!dot_pending) begin
               dot_ctl.finish = 1'b1;
               state_in       = train_ff ? ST_UPD : ST_IDLE;
            end
         end
         ST_UPD: begin
            issue = 1'b1;
            if (slot_ff == SLOT_W'(ROW - 1)) begin
               state_in = ST_UPD_WAIT;
               slot_in  = '0;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         ST_UPD_WAIT: begin
            if (!upd_pending) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
         beat_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         beat_ff.dot  <= issue && (state_ff == ST_DOT);
         beat_ff.upd  <= issue && (state_ff == ST_UPD);
         beat_ff.slot <= slot_ff;
      end
   end

   // Hold the item's fields for the whole operation
   always_ff @(posedge clock) begin
      if (accept) begin
         ubase_ff  <= u_row;
         ibase_ff  <= i_row;
         train_ff  <= (req_cmd == CMD_TRAIN);
         many_ff   <= req_user_rated_many;
         rating_ff <= req_rating;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff         <= MEAN_RESET;
         bias_rate_ff    <= RATE_RESET;
         factor_rate_ff  <= RATE_RESET;
         bias_decay_ff   <= DECAY_RESET;
         factor_decay_ff <= DECAY_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MEAN_RATING:  mean_ff         <= csr_write_data;
            CSR_BIAS_RATE:    bias_rate_ff    <= csr_write_data[RATE_W-1:0];
            CSR_FACTOR_RATE:  factor_rate_ff  <= csr_write_data[RATE_W-1:0];
            CSR_BIAS_DECAY:   bias_decay_ff   <= csr_write_data[RATE_W-1:0];
            CSR_FACTOR_DECAY: factor_decay_ff <= csr_write_data[RATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Write port select: update write-back or load
   always_comb begin
      uram_we    = user_wr.en | load_user;
      uram_waddr = user_wr.en ? ubase_ff + UADDR_W'(user_wr.slot) : u_load_addr;
      uram_wdata = user_wr.en ? user_wr.data : req_load_value;
      iram_we    = item_wr.en | load_item;
      iram_waddr = item_wr.en ? ibase_ff + IADDR_W'(item_wr.slot) : i_load_addr;
      iram_wdata = item_wr.en ? item_wr.data : req_load_value;
   end

   bfs_ram #(.DEPTH(UMEM_DEPTH), .WIDTH(W)) u_user_ram (
      .clock    (clock),
      .we       (uram_we),
      .waddr    (uram_waddr),
      .wdata    (uram_wdata),
      .re       (issue),
      .raddr    (ubase_ff + UADDR_W'(slot_ff)),
      .rdata_ff (rd_user)
   );

   bfs_ram #(.DEPTH(IMEM_DEPTH), .WIDTH(W)) u_item_ram (
      .clock    (clock),
      .we       (iram_we),
      .waddr    (iram_waddr),
      .wdata    (iram_wdata),
      .re       (issue),
      .raddr    (ibase_ff + IADDR_W'(slot_ff)),
      .rdata_ff (rd_item)
   );

   bfs_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dot_ctl),
      .beat      (beat_ff),
      .rd_user   (signed'(rd_user)),
      .rd_item   (signed'(rd_item)),
      .mean      (mean_ff),
      .rating    (rating_ff),
      .pending   (dot_pending),
      .strobe_ff (rsp_strobe),
      .pred_ff   (rsp_prediction),
      .err_ff    (rsp_error)
   );

   bfs_update u_update (
      .clock        (clock),
      .reset        (reset),
      .beat         (beat_ff),
      .rd_user      (signed'(rd_user)),
      .rd_item      (signed'(rd_item)),
      .err          (rsp_error),
      .bias_rate    (bias_rate_ff),
      .factor_rate  (factor_rate_ff),
      .bias_decay   (bias_decay_ff),
      .factor_decay (factor_decay_ff),
      .user_wr      (user_wr),
      .item_wr      (item_wr),
      .pending      (upd_pending)
   );

`ifndef SYNTH
   a_user_wb_phase: assert property (@(posedge clock) disable iff (reset)
      user_wr.en |-> (state_ff == ST_UPD || state_ff == ST_UPD_WAIT))
      else $error("user write-back outside update pass");

   a_item_wb_phase: assert property (@(posedge clock) disable iff (reset)
      item_wr.en |-> (state_ff == ST_UPD || state_ff == ST_UPD_WAIT))
      else $error("item write-back outside update pass");

   a_beat_excl: assert property (@(posedge clock) disable iff (reset)
      !(beat_ff.dot && beat_ff.upd))
      else $error("read beat tagged for both passes");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command[1]) |=> !busy)
      else $error("load left the block busy");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_DOT_WAIT))
      else $error("result strobe without finished prediction");
`endif

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the biased factor SGD update block.
module testbench;
   import bfs_pkg::*;

   localparam int LIMIT     = 1000000;
   localparam int SETTLE    = 100;
   localparam int POOL      = 4;
   localparam int N_PHASES  = 6;
   localparam int PHASE_LEN = 140;

   localparam int MEAN_SET[N_PHASES]   = '{235930, 0, 327680, 200000, 245760, 229376};
   localparam int BRATE_SET[N_PHASES]  = '{524, 0, 65535, 3000, 655, 1311};
   localparam int FRATE_SET[N_PHASES]  = '{524, 65535, 0, 3000, 655, 1311};
   localparam int BDECAY_SET[N_PHASES] = '{655, 65535, 0, 2000, 1000, 655};
   localparam int FDECAY_SET[N_PHASES] = '{655, 0, 65535, 2000, 1000, 655};

   typedef enum logic [1:0] {K_ITEM, K_CSR, K_DRAIN} kind_type;

   typedef struct packed {
      kind_type               kind;
      cmd_type                cmd;
      logic [15:0]            user;
      logic [14:0]            item;
      logic [RATING_W-1:0]    rating;
      logic                   many;
      logic [ENTRY_W-1:0]     slot;
      logic signed [W-1:0]    value;
      logic [CSR_IDX_W-1:0]   csr_idx;
      logic [CSR_W-1:0]       csr_data;
      logic [6:0]             idle;
   } tb_beat_type;

   typedef struct packed {
      logic [PRED_W-1:0]        pred;
      logic signed [ERR_W-1:0]  err;
   } rating_result_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic rsp_strobe;
   logic [PRED_W-1:0] rsp_prediction;
   logic signed [ERR_W-1:0] rsp_error;
   logic csr_write_enable;
   tb_beat_type cur = '0;

   tb_beat_type pending_beats[$];
   rating_result_type expected_ratings[$];

   // predictor state: row base index*ROW, slot 0 is the bias
   int user_rows[int];
   int item_rows[int];
   longint mean_q;
   longint bias_lr, factor_lr, bias_reg, factor_reg;

   int hold;
   int cycles;
   int errors;
   int n_train, n_predict, n_load, n_checked;
   logic [15:0] pool_user[POOL];
   logic [14:0] pool_item[POOL];

   biased_factor_sgd_update u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (cur.cmd),
      .req_user_index      (cur.user),
      .req_item_index      (cur.item),
      .req_rating          (cur.rating),
      .req_user_rated_many (cur.many),
      .req_entry_slot      (cur.slot),
      .req_load_value      (cur.value),
      .rsp_strobe          (rsp_strobe),
      .rsp_prediction      (rsp_prediction),
      .rsp_error           (rsp_error),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (cur.csr_idx),
      .csr_write_data      (cur.csr_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic longint round_mul(longint a, longint b);
      return (a * b + 64'sd32768) >>> 16;
   endfunction

   function automatic longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint sgd_step(longint w, longint grad, longint lr, longint reg_w);
      longint t;
      t = clip32(grad - round_mul(reg_w, w));
      return clip32(w + round_mul(lr, t));
   endfunction

   task automatic apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      case (idx)
         CSR_MEAN_RATING:  mean_q = data;
         CSR_BIAS_RATE:    bias_lr = data[RATE_W-1:0];
         CSR_FACTOR_RATE:  factor_lr = data[RATE_W-1:0];
         CSR_BIAS_DECAY:   bias_reg = data[RATE_W-1:0];
         CSR_FACTOR_DECAY: factor_reg = data[RATE_W-1:0];
         default: ;
      endcase
   endtask

   // Update the tables for one accepted beat and, for train and predict, work out its rating result
   task automatic predict_rating(tb_beat_type b);
      int bu, bi;
      longint pred, err, pu, qi;
      bu = int'(b.user) * ROW;
      bi = int'(b.item) * ROW;
      if (b.cmd == CMD_LOAD_USER || b.cmd == CMD_LOAD_ITEM) begin
         n_load++;
         if (b.slot <= NUM_FACTORS) begin
            if (b.cmd == CMD_LOAD_USER) user_rows[bu + b.slot] = b.value;
            else item_rows[bi + b.slot] = b.value;
         end
         return;
      end
      pred = mean_q + user_rows[bu] + item_rows[bi];
      if (b.many) begin
         for (int k = 1; k <= NUM_FACTORS; k++)
            pred += round_mul(user_rows[bu + k], item_rows[bi + k]);
      end
      if (pred < 65536) pred = 65536;
      if (pred > 327680) pred = 327680;
      err = 0;
      if (b.cmd == CMD_TRAIN) begin
         n_train++;
         err = longint'(b.rating) * 65536 - pred;
         if (err > ERR_LIM) err = ERR_LIM;
         if (err < -ERR_LIM) err = -ERR_LIM;
         user_rows[bu] = int'(sgd_step(user_rows[bu], err, bias_lr, bias_reg));
         item_rows[bi] = int'(sgd_step(item_rows[bi], err, bias_lr, bias_reg));
         // item factor sees the user factor just updated
         for (int k = 1; k <= NUM_FACTORS; k++) begin
            pu = user_rows[bu + k];
            qi = item_rows[bi + k];
            pu = sgd_step(pu, round_mul(err, qi), factor_lr, factor_reg);
            qi = sgd_step(qi, round_mul(err, pu), factor_lr, factor_reg);
            user_rows[bu + k] = int'(pu);
            item_rows[bi + k] = int'(qi);
         end
      end else begin
         n_predict++;
      end
      expected_ratings.insert(expected_ratings.size(), '{pred[PRED_W-1:0], err[ERR_W-1:0]});
   endtask

   task automatic report(string what, longint got, longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
      errors++;
   endtask

   // Driver: one beat at a time from the pending queue
   always @(posedge clock) begin
      tb_beat_type nxt;
      logic start_n, we_n;
      int hold_n;
      if (reset) begin
         start <= 1'b0;
         csr_write_enable <= 1'b0;
         hold <= 0;
      end else begin
         if (start && !busy) predict_rating(cur);
         if (csr_write_enable) apply_csr(cur.csr_idx, cur.csr_data);
         if (!(start && busy)) begin
            nxt = cur;
            start_n = 1'b0;
            we_n = 1'b0;
            hold_n = hold;
            if (hold > 0) begin
               hold_n = hold - 1;
            end else if (pending_beats.size() > 0) begin
               case (pending_beats[0].kind)
                  K_ITEM: begin
                     if ($urandom_range(99) >= pending_beats[0].idle) begin
                        nxt = pending_beats.pop_front();
                        start_n = 1'b1;
                     end
                  end
                  K_CSR: begin
                     nxt = pending_beats.pop_front();
                     we_n = 1'b1;
                  end
                  default: begin
                     // hold off until the block has gone quiet
                     if (expected_ratings.size() == 0 && !busy) begin
                        void'(pending_beats.pop_front());
                        hold_n = SETTLE;
                     end
                  end
               endcase
            end
            cur <= nxt;
            start <= start_n;
            csr_write_enable <= we_n;
            hold <= hold_n;
         end
      end
   end

   // Monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin
      rating_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_ratings.size() == 0) begin
            report("unexpected result, prediction", rsp_prediction, -1);
         end else begin
            want = expected_ratings.pop_front();
            n_checked++;
            if (rsp_prediction !== want.pred) report("prediction", rsp_prediction, want.pred);
            if (rsp_error !== want.err) report("error", rsp_error, want.err);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic add_item(cmd_type cmd, logic [15:0] u, logic [14:0] i, int rating,
                           int many, int slot, logic signed [W-1:0] v, int idle);
      tb_beat_type b;
      b = '0;
      b.kind = K_ITEM;
      b.cmd = cmd;
      b.user = u;
      b.item = i;
      b.rating = RATING_W'(rating);
      b.many = 1'(many);
      b.slot = ENTRY_W'(slot);
      b.value = v;
      b.idle = 7'(idle);
      pending_beats.insert(pending_beats.size(), b);
   endtask

   task automatic add_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      tb_beat_type b;
      b = '0;
      b.kind = K_CSR;
      b.cmd = CMD_TRAIN;
      b.csr_idx = idx;
      b.csr_data = data;
      pending_beats.insert(pending_beats.size(), b);
   endtask

   task automatic add_drain();
      tb_beat_type b;
      b = '0;
      b.kind = K_DRAIN;
      b.cmd = CMD_TRAIN;
      pending_beats.insert(pending_beats.size(), b);
   endtask

   function automatic logic signed [W-1:0] moderate_value(bit bias);
      if (bias) return int'($urandom_range(131072)) - 65536;
      return int'($urandom_range(80000)) - 40000;
   endfunction

   task automatic load_row(logic [15:0] u, logic [14:0] i, bit is_user, int idle);
      for (int s = 0; s <= NUM_FACTORS; s++)
         add_item(is_user ? CMD_LOAD_USER : CMD_LOAD_ITEM, u, i, 0, 0, s,
                  moderate_value(s == 0), idle);
   endtask

   task automatic add_random(int idle);
      int r, pu, pi, rating;
      r = $urandom_range(99);
      pu = $urandom_range(POOL - 1);
      pi = $urandom_range(POOL - 1);
      rating = ($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(5, 1);
      if (r < 55) begin
         add_item(CMD_TRAIN, pool_user[pu], pool_item[pi], rating, $urandom_range(3) != 0,
                  $urandom_range(63), $urandom, idle);
      end else if (r < 70) begin
         add_item(CMD_PREDICT, pool_user[pu], pool_item[pi], rating, $urandom_range(1),
                  $urandom_range(63), $urandom, idle);
      end else if (r < 84) begin
         // refresh a pool entry with a sane value
         r = $urandom_range(NUM_FACTORS);
         add_item($urandom_range(1) ? CMD_LOAD_USER : CMD_LOAD_ITEM, pool_user[pu],
                  pool_item[pi], rating, $urandom_range(1), r, moderate_value(r == 0), idle);
      end else if (r < 86) begin
         add_item($urandom_range(1) ? CMD_LOAD_USER : CMD_LOAD_ITEM, pool_user[pu],
                  pool_item[pi], rating, 0, $urandom_range(NUM_FACTORS), $urandom, idle);
      end else if (r < 94) begin
         // rows outside the pool are written but never read
         add_item($urandom_range(1) ? CMD_LOAD_USER : CMD_LOAD_ITEM, 16'($urandom),
                  15'($urandom), rating, $urandom_range(1), $urandom_range(NUM_FACTORS),
                  $urandom, idle);
      end else begin
         // slot beyond the row: dropped by the block
         add_item($urandom_range(1) ? CMD_LOAD_USER : CMD_LOAD_ITEM, pool_user[pu],
                  pool_item[pi], rating, $urandom_range(1), $urandom_range(63, NUM_FACTORS + 1),
                  $urandom, idle);
      end
   endtask

   initial begin
      int idle;
      reset = 1'b1;
      start = 1'b0;
      csr_write_enable = 1'b0;
      cycles = 0;
      errors = 0;
      mean_q = 0;
      bias_lr = 524;
      factor_lr = 524;
      bias_reg = 655;
      factor_reg = 655;

      pool_user[0] = 16'd0;
      pool_user[1] = 16'hFFFF;
      pool_item[0] = 15'd0;
      pool_item[1] = 15'h7FFF;
      for (int p = 2; p < POOL; p++) begin
         pool_user[p] = 16'($urandom);
         pool_item[p] = 15'($urandom);
      end
      for (int p = 0; p < POOL; p++) begin
         load_row(pool_user[p], pool_item[p], 1, 0);
         load_row(pool_user[p], pool_item[p], 0, 0);
      end

      // directed: every command, rating extremes and out-of-range ratings
      for (int r = 0; r <= 7; r++)
         add_item(CMD_TRAIN, pool_user[0], pool_item[1], r, r % 2, 0, 0, 0);
      add_item(CMD_PREDICT, pool_user[1], pool_item[0], 3, 1, 0, 0, 0);
      add_item(CMD_PREDICT, pool_user[1], pool_item[0], 3, 0, 0, 0, 0);
      add_item(CMD_LOAD_USER, pool_user[2], pool_item[2], 0, 0, 63, 32'sh7FFFFFFF, 0);
      add_item(CMD_LOAD_ITEM, pool_user[2], pool_item[2], 0, 0, 33, 32'sh80000000, 0);
      // saturation: extreme bias and factor values
      add_item(CMD_LOAD_USER, pool_user[3], pool_item[3], 0, 0, 0, 32'sh7FFFFFFF, 0);
      add_item(CMD_LOAD_USER, pool_user[3], pool_item[3], 0, 0, 1, 32'sh7FFFFFFF, 0);
      add_item(CMD_LOAD_ITEM, pool_user[3], pool_item[3], 0, 0, 1, 32'sh80000000, 0);
      add_item(CMD_LOAD_ITEM, pool_user[3], pool_item[3], 0, 0, 32, 32'sh80000000, 0);
      add_item(CMD_TRAIN, pool_user[3], pool_item[3], 1, 1, 0, 0, 0);
      add_item(CMD_TRAIN, pool_user[3], pool_item[3], 5, 0, 0, 0, 0);
      add_item(CMD_PREDICT, pool_user[3], pool_item[3], 5, 1, 0, 0, 0);
      load_row(pool_user[3], pool_item[3], 1, 0);
      load_row(pool_user[3], pool_item[3], 0, 0);

      // random phases, each under its own register setting
      for (int ph = 0; ph < N_PHASES; ph++) begin
         idle = (ph < 2) ? 28 : (ph < 4) ? 52 : 0;
         add_drain();
         add_csr(CSR_MEAN_RATING, CSR_W'(MEAN_SET[ph]));
         add_csr(CSR_BIAS_RATE, CSR_W'(BRATE_SET[ph]));
         add_csr(CSR_FACTOR_RATE, CSR_W'(FRATE_SET[ph]));
         add_csr(CSR_BIAS_DECAY, CSR_W'(BDECAY_SET[ph]));
         add_csr(CSR_FACTOR_DECAY, CSR_W'(FDECAY_SET[ph]));
         for (int n = 0; n < PHASE_LEN; n++) add_random(idle);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_beats.size() == 0 && expected_ratings.size() == 0 && !start);
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d train, %0d predict, %0d load beats over %0d register settings",
               n_train, n_predict, n_load, N_PHASES + 1);
      $display("checked %0d results, %0d mismatches", n_checked, errors);
      if (errors == 0 && expected_ratings.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### biased_factor_sgd_update.f
rtl/core/bfs_pkg.sv
rtl/core/bfs_ram.sv
rtl/core/bfs_dot.sv
rtl/core/bfs_update.sv
rtl/core/biased_factor_sgd_update.sv
dv/testbench.sv
